// ===== rtl/core/adm_pkg.sv =====
// shared constants, types and controller states for the mono downmix and level meter
// no dependencies; compile first

package adm_pkg;

	// field widths
	localparam int SAMPLE_W = 24;
	localparam int PCM_W    = 16;
	localparam int LEVEL_W  = 17;
	localparam int CC_W     = 4;

	// internal widths
	localparam int POS_W   = 3;
	localparam int FSUM_W  = 27;
	localparam int MAG_W   = 24;
	localparam int PROD_W  = 2 * MAG_W;
	localparam int MCNT_W  = 5;
	localparam int SQACC_W = 58;
	localparam int FCNT_W  = 11;
	localparam int OPND_W  = 64;
	localparam int STEP_W  = 7;
	localparam int DVSR_W  = 11;
	localparam int ROOT_W  = 29;
	localparam int ROOT2_W = 21;
	localparam int SREM_W  = 32;

	// limits and fixed-point constants
	localparam int MAX_CHANNELS     = 8;
	localparam int MAX_BLOCK_FRAMES = 1024;
	localparam int ONE_Q20          = 1 << 20;
	localparam int LEVEL_MAX        = 65536;
	localparam int LEVEL_DIV        = 5;

	// step counts of the serial units
	localparam int MONO_STEPS  = FSUM_W;
	localparam int MEAN_STEPS  = SQACC_W;
	localparam int RMS_STEPS   = ROOT_W;
	localparam int ROOT_STEPS  = ROOT2_W;
	localparam int SCALE_STEPS = ROOT2_W + 3;

	// start command and status of a serial unit
	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MONO_GO,
		ST_MONO_WAIT,
		ST_SQ,
		ST_ACC,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_RMS_GO,
		ST_RMS_WAIT,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_SCALE_GO,
		ST_SCALE_WAIT,
		ST_PUSH
	} state_t;

endpackage

// ===== rtl/core/adm_ifs.sv =====
// valid/ready channel interfaces: sample input, result output, register write
// depends on adm_pkg for field widths

interface adm_in_if;
	logic                        valid;
	logic                        ready;
	logic [adm_pkg::SAMPLE_W-1:0] sample;
	logic                        block_end;

	modport source (output valid, output sample, output block_end, input ready);
	modport sink (input valid, input sample, input block_end, output ready);
endinterface

interface adm_out_if;
	logic                       valid;
	logic                       ready;
	logic [adm_pkg::PCM_W-1:0]   pcm_sample;
	logic [adm_pkg::LEVEL_W-1:0] level;
	logic                       level_valid;

	modport source (output valid, output pcm_sample, output level, output level_valid,
		input ready);
	modport sink (input valid, input pcm_sample, input level, input level_valid,
		output ready);
endinterface

interface adm_cfg_if;
	logic                    valid;
	logic                    ready;
	logic [adm_pkg::CC_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/adm_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// dividend is loaded left-aligned; after N steps the quotient sits in the low N bits
// depends on adm_pkg

module adm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  adm_pkg::unit_cmd_t        cmd,
	input  logic [adm_pkg::OPND_W-1:0] dividend,
	input  logic [adm_pkg::DVSR_W-1:0] divisor,
	output adm_pkg::unit_sts_t        sts,
	output logic [adm_pkg::OPND_W-1:0] quotient
);
	import adm_pkg::*;

	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [OPND_W-1:0] quo_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [DVSR_W:0]   part;
	logic [DVSR_W:0]   diff;
	logic              ge;

	// trial subtract of the divisor from the shifted remainder
	assign part = {rem_q, quo_q[OPND_W-1]};
	assign ge   = part >= {1'b0, dvsr_q};
	assign diff = part - {1'b0, dvsr_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (cmd.start) begin
			cnt_q  <= cmd.steps;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DVSR_W-1:0] : part[DVSR_W-1:0];
			quo_q <= {quo_q[OPND_W-2:0], ge};
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/adm_sqrt.sv =====
// digit-serial integer square root, one root bit (two radicand bits) per cycle
// radicand is loaded left-aligned; result is floor(sqrt) of the top 2N bits
// depends on adm_pkg

module adm_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  adm_pkg::unit_cmd_t        cmd,
	input  logic [adm_pkg::OPND_W-1:0] radicand,
	output adm_pkg::unit_sts_t        sts,
	output logic [adm_pkg::ROOT_W-1:0] root
);
	import adm_pkg::*;

	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [OPND_W-1:0] v_q;
	logic [SREM_W-1:0] r_q;
	logic [ROOT_W-1:0] q_q;
	logic [SREM_W+1:0] part;
	logic [SREM_W+1:0] trial;
	logic [SREM_W+1:0] diff;
	logic              ge;

	// bring down two bits and try root*4 + 1
	assign part  = {r_q, v_q[OPND_W-1 -: 2]};
	assign trial = {{(SREM_W - ROOT_W){1'b0}}, q_q, 2'b01};
	assign ge    = part >= trial;
	assign diff  = part - trial;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (cmd.start) begin
			cnt_q  <= cmd.steps;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// radicand, remainder and root shift registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			v_q <= radicand;
			r_q <= '0;
			q_q <= '0;
		end else if (cnt_q != '0) begin
			v_q <= {v_q[OPND_W-3:0], 2'b00};
			r_q <= ge ? diff[SREM_W-1:0] : part[SREM_W-1:0];
			q_q <= {q_q[ROOT_W-2:0], ge};
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign root     = q_q;

endmodule

// ===== rtl/core/audio_downmix_pcm16_level_meter.sv =====
// top level: multichannel downmix to pcm16 with block level meter
// depends on adm_pkg, adm_ifs, adm_div and adm_sqrt
//
// Usage: interleaved Q3.20 channel samples enter on din, one transaction per
// sample. A sample that does not close a frame is summed in the cycle it is
// taken and din is ready again on the next cycle. The sample that closes a
// frame starts a serial run: a 27-step divide by the channel count, a 24-step
// shift-add square and the accumulate; the result is then offered on dout.
// With block_end set on that sample the level follows from a 58-step divide
// by the frame count, square roots of 29 and 21 steps and a 24-step divide
// by five. The shared serial divider and the square root unit set these
// figures. din stays low-ready during that run. dout is a register: one result
// may wait there while the next frame is gathered; a stalled dout holds the
// next result in the controller and din stays low-ready until the slot frees.
// cfg is always ready; writing the channel count drops any partly gathered
// frame. Reset clears the frame and block sums, sets the channel count to one
// and empties dout.

module audio_downmix_pcm16_level_meter (
	input  logic      clk,
	input  logic      arst_n,
	adm_in_if.sink    din,
	adm_out_if.source dout,
	adm_cfg_if.sink   cfg
);
	import adm_pkg::*;

	state_t state_q, state_d;

	logic [CC_W-1:0]    cc_q;
	logic [CC_W-1:0]    cc_eff;
	logic [FSUM_W-1:0]  frame_sum_q;
	logic [POS_W-1:0]   pos_q;
	logic [FSUM_W-1:0]  msum_q;
	logic               end_q;
	logic [MAG_W-1:0]   mag_q;
	logic [PROD_W-1:0]  prod_q;
	logic [MCNT_W-1:0]  mcnt_q;
	logic [SQACC_W-1:0] acc_q;
	logic [FCNT_W-1:0]  fcnt_q;
	logic [PCM_W-1:0]   pcm_q;
	logic [LEVEL_W-1:0] level_q;
	logic               lvalid_q;
	logic               ovalid_q;
	logic [PCM_W-1:0]   opcm_q;
	logic [LEVEL_W-1:0] olevel_q;
	logic               olvalid_q;

	logic               accept;
	logic               cfg_wr;
	logic               frame_done;
	logic [FSUM_W-1:0]  sum_next;
	logic [FSUM_W-1:0]  msum_mag;
	logic               push;
	logic [MAG_W:0]     mul_sum;
	logic [20:0]        cmag;
	logic [21:0]        cval;
	logic [36:0]        scaled;
	logic               blk_full;

	unit_cmd_t          div_cmd;
	unit_sts_t          div_sts;
	logic [OPND_W-1:0]  div_opnd;
	logic [DVSR_W-1:0]  div_dvsr;
	logic [OPND_W-1:0]  div_quo;
	unit_cmd_t          sqrt_cmd;
	unit_sts_t          sqrt_sts;
	logic [OPND_W-1:0]  sqrt_opnd;
	logic [ROOT_W-1:0]  sqrt_root;

	// serial units
	adm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_opnd),
		.divisor  (div_dvsr),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	adm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (sqrt_cmd),
		.radicand (sqrt_opnd),
		.sts      (sqrt_sts),
		.root     (sqrt_root)
	);

	// handshakes
	assign din.ready = (state_q == ST_IDLE);
	assign accept    = din.valid && din.ready;
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign push      = (state_q == ST_PUSH) && (!ovalid_q || dout.ready);

	// effective channel count: zero acts as one, clipped to the maximum
	always_comb begin
		if (cc_q == '0) begin
			cc_eff = CC_W'(1);
		end else if (cc_q > CC_W'(MAX_CHANNELS)) begin
			cc_eff = CC_W'(MAX_CHANNELS);
		end else begin
			cc_eff = cc_q;
		end
	end

	// frame gathering
	assign sum_next   = frame_sum_q + {{(FSUM_W - SAMPLE_W){din.sample[SAMPLE_W-1]}}, din.sample};
	assign frame_done = ({1'b0, pos_q} + CC_W'(1)) >= cc_eff;
	assign msum_mag   = msum_q[FSUM_W-1] ? (~msum_q + 1'b1) : msum_q;
	assign blk_full   = (fcnt_q >= FCNT_W'(MAX_BLOCK_FRAMES));

	// serial square step: add multiplicand into upper half on a set bit
	assign mul_sum = {1'b0, prod_q[PROD_W-1:MAG_W]} + (prod_q[0] ? {1'b0, mag_q} : '0);

	// clamp to +-1.0, scale by 32767 and round half up
	assign cmag   = (mag_q > MAG_W'(ONE_Q20)) ? 21'(ONE_Q20) : mag_q[20:0];
	assign cval   = msum_q[FSUM_W-1] ? (22'(0) - {1'b0, cmag}) : {1'b0, cmag};
	assign scaled = {cval, 15'b0} - {{15{cval[21]}}, cval} + 37'(ONE_Q20 / 2);

	// register write and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CC_W'(1);
		end else if (cfg_wr) begin
			cc_q <= cfg.data;
		end
	end

	// frame sum and channel position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_sum_q <= '0;
			pos_q       <= '0;
		end else if (cfg_wr) begin
			frame_sum_q <= '0;
			pos_q       <= '0;
		end else if (accept) begin
			if (frame_done) begin
				frame_sum_q <= '0;
				pos_q       <= '0;
			end else begin
				frame_sum_q <= sum_next;
				pos_q       <= pos_q + 1'b1;
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and unit commands
	always_comb begin
		state_d   = state_q;
		div_cmd   = '0;
		div_opnd  = '0;
		div_dvsr  = '0;
		sqrt_cmd  = '0;
		sqrt_opnd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && frame_done) begin
					state_d = ST_MONO_GO;
				end
			end
			ST_MONO_GO: begin
				div_cmd.start = 1'b1;
				div_cmd.steps = STEP_W'(MONO_STEPS);
				div_opnd      = {msum_mag, {(OPND_W - FSUM_W){1'b0}}};
				div_dvsr      = {{(DVSR_W - CC_W){1'b0}}, cc_eff};
				state_d       = ST_MONO_WAIT;
			end
			ST_MONO_WAIT: begin
				if (div_sts.done) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (mcnt_q == MCNT_W'(1)) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = end_q ? ST_MEAN_GO : ST_PUSH;
			end
			ST_MEAN_GO: begin
				div_cmd.start = 1'b1;
				div_cmd.steps = STEP_W'(MEAN_STEPS);
				div_opnd      = {acc_q, {(OPND_W - SQACC_W){1'b0}}};
				div_dvsr      = fcnt_q;
				state_d       = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (div_sts.done) begin
					state_d = ST_RMS_GO;
				end
			end
			ST_RMS_GO: begin
				sqrt_cmd.start = 1'b1;
				sqrt_cmd.steps = STEP_W'(RMS_STEPS);
				sqrt_opnd      = {div_quo[SQACC_W-1:0], {(OPND_W - SQACC_W){1'b0}}};
				state_d        = ST_RMS_WAIT;
			end
			ST_RMS_WAIT: begin
				if (sqrt_sts.done) begin
					state_d = ST_ROOT_GO;
				end
			end
			ST_ROOT_GO: begin
				// rms * 2^12 placed in the top 42 bits
				sqrt_cmd.start = 1'b1;
				sqrt_cmd.steps = STEP_W'(ROOT_STEPS);
				sqrt_opnd      = {1'b0, sqrt_root, {(OPND_W - ROOT_W - 1){1'b0}}};
				state_d        = ST_ROOT_WAIT;
			end
			ST_ROOT_WAIT: begin
				if (sqrt_sts.done) begin
					state_d = ST_SCALE_GO;
				end
			end
			ST_SCALE_GO: begin
				// root * 8 divided by five
				div_cmd.start = 1'b1;
				div_cmd.steps = STEP_W'(SCALE_STEPS);
				div_opnd      = {sqrt_root[ROOT2_W-1:0], 3'b000,
					{(OPND_W - SCALE_STEPS){1'b0}}};
				div_dvsr      = DVSR_W'(LEVEL_DIV);
				state_d       = ST_SCALE_WAIT;
			end
			ST_SCALE_WAIT: begin
				if (div_sts.done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (push) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// captured frame and block flag
	always_ff @(posedge clk) begin
		if (accept && frame_done) begin
			msum_q <= sum_next;
			end_q  <= din.block_end;
		end
	end

	// mono magnitude and serial square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (state_q == ST_MONO_WAIT && div_sts.done) begin
			mcnt_q <= MCNT_W'(MAG_W);
		end else if (state_q == ST_SQ) begin
			mcnt_q <= mcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MONO_WAIT && div_sts.done) begin
			mag_q  <= div_quo[MAG_W-1:0];
			prod_q <= {{MAG_W{1'b0}}, div_quo[MAG_W-1:0]};
		end else if (state_q == ST_SQ) begin
			prod_q <= {mul_sum, prod_q[MAG_W-1:1]};
		end
	end

	// pcm value from the clamped mono sample
	always_ff @(posedge clk) begin
		if (state_q == ST_ACC) begin
			pcm_q <= scaled[35:20];
		end
	end

	// square sum and frame count of the running block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fcnt_q <= '0;
		end else if (state_q == ST_ACC && !blk_full) begin
			acc_q  <= acc_q + {{(SQACC_W - PROD_W){1'b0}}, prod_q};
			fcnt_q <= fcnt_q + 1'b1;
		end else if (state_q == ST_SCALE_WAIT && div_sts.done) begin
			acc_q  <= '0;
			fcnt_q <= '0;
		end
	end

	// level of the closed block
	always_ff @(posedge clk) begin
		if (state_q == ST_ACC) begin
			level_q  <= '0;
			lvalid_q <= 1'b0;
		end else if (state_q == ST_SCALE_WAIT && div_sts.done) begin
			level_q  <= (div_quo[SCALE_STEPS-1:0] > SCALE_STEPS'(LEVEL_MAX)) ?
				LEVEL_W'(LEVEL_MAX) : div_quo[LEVEL_W-1:0];
			lvalid_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (push) begin
			ovalid_q <= 1'b1;
		end else if (dout.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			opcm_q    <= pcm_q;
			olevel_q  <= level_q;
			olvalid_q <= lvalid_q;
		end
	end

	assign dout.valid       = ovalid_q;
	assign dout.pcm_sample  = opcm_q;
	assign dout.level       = olevel_q;
	assign dout.level_valid = olvalid_q;

`ifndef SYNTHESIS
	// channel position stays inside the frame
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < cc_eff)
		else $error("channel position beyond channel count");

	// block frame count never passes the cap
	a_fcnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FCNT_W'(MAX_BLOCK_FRAMES))
		else $error("frame count above block limit");

	// the serial units never run at once
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_sts.busy && sqrt_sts.busy))
		else $error("divider and square root busy together");

	// a result without a closed block carries a zero level, and level is capped
	a_level_ok: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.level <= LEVEL_W'(LEVEL_MAX))
			&& (dout.level_valid || dout.level == '0))
		else $error("bad level on result");

	// input is held off while a frame result is in flight
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_done |=> !din.ready)
		else $error("input taken during frame processing");
`endif

endmodule

// ===== dv/audio_downmix_pcm16_level_meter_tb.sv =====
// testbench for the mono downmix / pcm16 / block level meter: directed table, then random blocks
// checks each output transaction against an in-bench downmix and level predictor
// depends on adm_pkg, adm_ifs and the audio_downmix_pcm16_level_meter rtl

`timescale 1ns / 100ps

module audio_downmix_pcm16_level_meter_tb;
	import adm_pkg::*;

	localparam int PCM_FULL      = 32767;
	localparam int LEVEL_NUM     = 8;
	localparam int LEVEL_DEN     = 5;
	localparam int SETTLE_CYCLES = 250;
	localparam int LONG_HOLD     = 400;
	localparam int MAX_REPORTS   = 10;
	localparam int N_ROWS        = 30;

	typedef struct packed {
		logic [PCM_W-1:0]   pcm;
		logic [LEVEL_W-1:0] level;
		logic               lvl_valid;
	} mix_result_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CC_W-1:0]      chans;
		logic [SAMPLE_W-1:0]  smp;
		logic                 blk_end;
		logic                 typed;
		mix_result_t          want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	adm_in_if  din_if();
	adm_out_if dout_if();
	adm_cfg_if cfg_if();

	audio_downmix_pcm16_level_meter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	// predictor state
	logic [CC_W-1:0] chan_setting;
	longint          mix_sum;
	int unsigned     mix_pos;
	logic [63:0]     energy_sum;
	int unsigned     block_frames;

	mix_result_t pcm_frame_q[$];
	int unsigned fault_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned holds_asked;
	int unsigned holds_taken;
	int unsigned hold_left;

	// directed stimulus; typed rows carry their expected transaction
	stim_row_t directed_rows [N_ROWS] = '{
		// zero frame closing a block: level zero
		'{ROW_ITEM,  4'd0, 24'h000000, 1'b1, 1'b1, '{16'sd0, 17'd0, 1'b1}},
		// full scale and clamping at both ends
		'{ROW_ITEM,  4'd0, 24'h100000, 1'b0, 1'b1, '{16'sd32767, 17'd0, 1'b0}},
		'{ROW_ITEM,  4'd0, 24'h7FFFFF, 1'b0, 1'b1, '{16'sd32767, 17'd0, 1'b0}},
		'{ROW_ITEM,  4'd0, 24'h800000, 1'b1, 1'b1, '{-16'sd32767, 17'd65536, 1'b1}},
		'{ROW_ITEM,  4'd0, 24'hF00000, 1'b0, 1'b1, '{-16'sd32767, 17'd0, 1'b0}},
		// rounding near zero
		'{ROW_ITEM,  4'd0, 24'h000001, 1'b0, 1'b1, '{16'sd0, 17'd0, 1'b0}},
		'{ROW_ITEM,  4'd0, 24'hFFFFFF, 1'b0, 1'b1, '{16'sd0, 17'd0, 1'b0}},
		'{ROW_ITEM,  4'd0, 24'h000011, 1'b1, 1'b0, '0},
		// three channels, block end on a mid-frame sample is ignored
		'{ROW_WRITE, 4'd3, 24'h000000, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h123456, 1'b1, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'hFEDCBA, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h0ABCDE, 1'b1, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h7FFFFF, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h7FFFFF, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h7FFFFF, 1'b1, 1'b0, '0},
		// channel count zero behaves as one
		'{ROW_WRITE, 4'd0, 24'h000000, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h555555, 1'b1, 1'b0, '0},
		// channel count above the maximum behaves as the maximum
		'{ROW_WRITE, 4'd15, 24'h000000, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'hAAAAAA, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h555555, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h800000, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h800000, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h7FFFFF, 1'b1, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h000000, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'hFFFFFF, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h0FFFFF, 1'b1, 1'b0, '0},
		// register write drops a partly gathered frame
		'{ROW_WRITE, 4'd2, 24'h000000, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h400000, 1'b0, 1'b0, '0},
		'{ROW_WRITE, 4'd1, 24'h000000, 1'b0, 1'b0, '0},
		'{ROW_ITEM,  4'd0, 24'h080000, 1'b1, 1'b0, '0}
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard limit on run time
	initial begin
		#20ms;
		$display("audio_downmix_pcm16_level_meter_tb NOT OK");
		$finish;
	end

	// bitwise integer square root, floor
	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] trial;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	// channels actually averaged for the current setting
	function automatic int unsigned frame_width();
		if (chan_setting == 0)
			return 1;
		if (chan_setting > MAX_CHANNELS)
			return MAX_CHANNELS;
		return 32'(chan_setting);
	endfunction

	// advance the downmix state by one sample; returns 1 when a frame closes
	function automatic bit downmix_step(logic [SAMPLE_W-1:0] smp, bit blk_end,
		output mix_result_t res);
		longint      s;
		longint      mono;
		longint      clamped;
		longint      scaled;
		longint      width;
		logic [63:0] mag;
		logic [63:0] rms;
		logic [63:0] root;
		logic [63:0] lvl;
		res = '0;
		width = longint'(frame_width());
		s = longint'($signed(smp));
		mix_sum += s;
		mix_pos++;
		if (mix_pos < width)
			return 0;
		mono = mix_sum / width;
		mix_sum = 0;
		mix_pos = 0;
		// frames past the block limit give pcm only
		if (block_frames < MAX_BLOCK_FRAMES) begin
			mag = (mono < 0) ? -mono : mono;
			energy_sum += mag * mag;
			block_frames++;
		end
		clamped = mono;
		if (clamped > ONE_Q20)
			clamped = ONE_Q20;
		if (clamped < -ONE_Q20)
			clamped = -ONE_Q20;
		scaled = clamped * PCM_FULL + (ONE_Q20 / 2);
		res.pcm = PCM_W'(scaled >>> 20);
		if (blk_end) begin
			lvl = '0;
			if (block_frames != 0) begin
				rms = int_sqrt(energy_sum / 64'(block_frames));
				root = int_sqrt(rms << 12);
				lvl = (root * LEVEL_NUM) / LEVEL_DEN;
				if (lvl > LEVEL_MAX)
					lvl = LEVEL_MAX;
			end
			res.level = lvl[LEVEL_W-1:0];
			res.lvl_valid = 1'b1;
			energy_sum = '0;
			block_frames = 0;
		end
		return 1;
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int raw;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: raw = 8388607;
					1: raw = -8388608;
					2: raw = ONE_Q20;
					3: raw = -ONE_Q20;
					default: raw = 0;
				endcase
			end
			1, 2: raw = $urandom;
			3, 4, 5, 6: raw = $urandom_range(2 * ONE_Q20) - ONE_Q20;
			7, 8: raw = int'($urandom_range(8191)) - 4096;
			default: raw = int'($urandom_range(127)) - 64;
		endcase
		return raw[SAMPLE_W-1:0];
	endfunction

	// offer one sample, wait for the transaction, record what it should produce
	task automatic push_sample(logic [SAMPLE_W-1:0] smp, bit blk_end, bit typed,
		mix_result_t typed_res);
		mix_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid     <= 1'b1;
		din_if.sample    <= smp;
		din_if.block_end <= blk_end;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		if (downmix_step(smp, blk_end, res)) begin
			if (typed)
				res = typed_res;
			pcm_frame_q.push_back(res);
		end
	endtask

	task automatic wait_drained();
		din_if.valid <= 1'b0;
		while (pcm_frame_q.size() != 0)
			@(posedge clk);
	endtask

	// channel count write, only with the block idle
	task automatic write_channels(logic [CC_W-1:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		chan_setting = v;
		mix_sum = 0;
		mix_pos = 0;
		cfg_if.valid <= 1'b0;
	endtask

	// well-formed blocks of whole frames, with stray samples and stray block ends
	task automatic run_blocks(int unsigned n_items);
		int unsigned sent;
		int unsigned frames;
		int unsigned width;
		bit          be;
		bit          closing;
		sent = 0;
		width = frame_width();
		while (sent < n_items) begin
			if ($urandom_range(19) == 0) begin
				push_sample(rand_sample(), bit'($urandom_range(1)), 1'b0, '0);
				sent++;
			end
			frames = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
			for (int f = 0; f < frames; f++) begin
				for (int c = 0; c < width; c++) begin
					closing = (c == width - 1) && (f == frames - 1);
					if (closing)
						be = ($urandom_range(9) != 0);
					else
						be = ($urandom_range(7) == 0);
					push_sample(rand_sample(), be, 1'b0, '0);
					sent++;
				end
			end
		end
	endtask

	// output side: ready pattern, long hold-offs and checking
	initial begin
		dout_if.ready <= 1'b0;
		hold_left = 0;
		holds_taken = 0;
		forever begin
			@(posedge clk);
			begin
				mix_result_t want;
				mix_result_t got;
				if (arst_n && dout_if.valid && dout_if.ready) begin
					got = '{dout_if.pcm_sample, dout_if.level, dout_if.level_valid};
					if (pcm_frame_q.size() == 0) begin
						fault_count++;
						if (fault_count <= MAX_REPORTS)
							$display("%0t unexpected transaction pcm=%0d level=%0d lv=%0b",
								$realtime, $signed(got.pcm), got.level, got.lvl_valid);
					end else begin
						want = pcm_frame_q.pop_front();
						if (got !== want) begin
							fault_count++;
							if (fault_count <= MAX_REPORTS)
								$display("%0t mismatch exp/got pcm %0d/%0d lvl %0d/%0d lv %0b/%0b",
									$realtime,
									$signed(want.pcm), $signed(got.pcm), want.level, got.level,
									want.lvl_valid, got.lvl_valid);
						end
					end
				end
				if (hold_left > 0) begin
					dout_if.ready <= 1'b0;
					hold_left--;
				end else if (holds_taken != holds_asked) begin
					holds_taken++;
					hold_left = LONG_HOLD;
					dout_if.ready <= 1'b0;
				end else begin
					dout_if.ready <= ($urandom_range(99) >= recv_stall_pct);
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [CC_W-1:0] phase_chans [10] = '{4'd1, 4'd2, 4'd8, 4'd0, 4'd15,
			4'd3, 4'd5, 4'd7, 4'd4, 4'd9};
		arst_n           <= 1'b0;
		din_if.valid     <= 1'b0;
		din_if.sample    <= '0;
		din_if.block_end <= 1'b0;
		cfg_if.valid     <= 1'b0;
		cfg_if.data      <= '0;
		chan_setting = 4'd1;
		mix_sum = 0;
		mix_pos = 0;
		energy_sum = '0;
		block_frames = 0;
		fault_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holds_asked = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE)
				write_channels(directed_rows[i].chans);
			else
				push_sample(directed_rows[i].smp, directed_rows[i].blk_end,
					directed_rows[i].typed, directed_rows[i].want);
		end

		// random phases over channel settings and idle patterns
		foreach (phase_chans[p]) begin
			write_channels(phase_chans[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			// long output hold-off while input keeps coming, fills the block
			if (p == 0)
				holds_asked++;
			run_blocks(12);
			// input pause until all pending transactions are out
			if (p == 2)
				wait_drained();
			run_blocks(12);
		end

		// one block longer than the frame limit
		write_channels(4'd1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < MAX_BLOCK_FRAMES + 4; i++)
			push_sample(rand_sample(), 1'b0, 1'b0, '0);
		push_sample(rand_sample(), 1'b1, 1'b0, '0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && pcm_frame_q.size() == 0)
			$display("audio_downmix_pcm16_level_meter_tb OK");
		else
			$display("audio_downmix_pcm16_level_meter_tb NOT OK");
		$finish;
	end

endmodule
